### src/adb_kbd_pkg.sv
// shared types and constants for the desktop-bus keyboard event fifo
// no dependencies
package adb_kbd_pkg;

  localparam int FIFO_DEPTH = 16;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  localparam logic [2:0] REQ_KEY_DOWN  = 3'd0;
  localparam logic [2:0] REQ_KEY_UP    = 3'd1;
  localparam logic [2:0] REQ_TALK_R0   = 3'd2;
  localparam logic [2:0] REQ_TALK_R2   = 3'd3;
  localparam logic [2:0] REQ_TALK_DONE = 3'd4;
  localparam logic [2:0] REQ_FLUSH     = 3'd5;

  localparam logic [7:0]  RELEASE_BIT = 8'h80;
  localparam logic [7:0]  NO_CODE     = 8'hff;
  localparam logic [15:0] REG2_WORD   = 16'hffff;
  localparam logic [1:0]  TALK_BYTES  = 2'd2;

  typedef struct packed {
    logic [2:0] req_type;
    logic [6:0] key_code;
  } in_t;

  typedef struct packed {
    logic [1:0]  talk_len;
    logic [15:0] talk_data;
    logic        srq;
  } out_t;

endpackage

### src/adb_keyboard_event_fifo_top.sv
// desktop-bus keyboard event fifo serving talk register 0
// depends on adb_kbd_pkg
//
// Takes one request word per cycle and gives exactly one result word for each,
// in order. A request passes an input register, is resolved by short logic and
// lands in a result register; the rate is one word per clock while the consumer
// keeps up, the only limit being the result register, which holds a
// word until the consumer takes it. Key-down and key-up push a code (bit 7 set
// on release) into a ring fifo of FIFO_DEPTH slots that holds FIFO_DEPTH-1
// codes; a push to a full fifo is lost. A talk to register 0 pops up to two
// codes into a held word (0xff stands in for a missing second code) and repeats
// that word until talk-done; with the fifo empty and no talk open it returns no
// bytes. A talk to register 2 returns 0xffff. The service request follows fifo
// occupancy on key events and talk-done, and flush clears everything.
module adb_keyboard_event_fifo_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  adb_kbd_pkg::in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output adb_kbd_pkg::out_t  out_data
);
  import adb_kbd_pkg::*;

  // code store, no reset: only entries between the pointers are ever used
  logic [7:0] mem [FIFO_DEPTH];

  // input register
  logic             in_v_r;
  in_t              in_r;

  // result register
  logic             out_v_r;
  out_t             out_r;
  out_t             res;

  // control state
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic             tip_r, tip_nxt;
  logic [15:0]      held_r, held_nxt;
  logic             svc_r, svc_nxt;

  // head prefetch: codes at rd_ptr and rd_ptr+1, with write forwarding
  logic [7:0]       head0_mem_r, head1_mem_r;
  logic             fwd0_r, fwd1_r;
  logic [7:0]       fwd_data_r;
  logic [7:0]       head0, head1;

  logic             fire;
  logic             we;
  logic [7:0]       wdata;
  logic [PTR_W-1:0] ra0, ra1;
  logic [PTR_W-1:0] wr_inc, rd_inc, rd_inc2;
  logic             full, empty, one_left;

  // a word moves on when the result register is free or being drained
  assign fire     = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || fire;

  assign head0 = fwd0_r ? fwd_data_r : head0_mem_r;
  assign head1 = fwd1_r ? fwd_data_r : head1_mem_r;

  assign wr_inc   = wr_ptr_r + PTR_W'(1);
  assign rd_inc   = rd_ptr_r + PTR_W'(1);
  assign rd_inc2  = rd_ptr_r + PTR_W'(2);
  assign full     = (wr_inc == rd_ptr_r);
  assign empty    = (rd_ptr_r == wr_ptr_r);
  assign one_left = (rd_inc == wr_ptr_r);

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    tip_nxt    = tip_r;
    held_nxt   = held_r;
    svc_nxt    = svc_r;
    we         = 1'b0;
    wdata      = {1'b0, in_r.key_code};
    res.talk_len  = '0;
    res.talk_data = '0;
    if (fire) begin
      unique case (in_r.req_type) inside
        REQ_KEY_DOWN, REQ_KEY_UP: begin
          if (in_r.req_type == REQ_KEY_UP) begin
            wdata = {1'b0, in_r.key_code} | RELEASE_BIT;
          end
          if (!full) begin
            we         = 1'b1;
            wr_ptr_nxt = wr_inc;
          end
          svc_nxt = (rd_ptr_r != wr_ptr_nxt);
        end
        REQ_TALK_R0: begin
          if (tip_r) begin
            res.talk_len  = TALK_BYTES;
            res.talk_data = held_r;
          end else if (!empty) begin
            if (one_left) begin
              held_nxt   = {head0, NO_CODE};
              rd_ptr_nxt = rd_inc;
            end else begin
              held_nxt   = {head0, head1};
              rd_ptr_nxt = rd_inc2;
            end
            tip_nxt       = 1'b1;
            res.talk_len  = TALK_BYTES;
            res.talk_data = held_nxt;
          end
        end
        REQ_TALK_R2: begin
          res.talk_len  = TALK_BYTES;
          res.talk_data = REG2_WORD;
        end
        REQ_TALK_DONE: begin
          tip_nxt = 1'b0;
          svc_nxt = !empty;
        end
        REQ_FLUSH: begin
          rd_ptr_nxt = '0;
          wr_ptr_nxt = '0;
          tip_nxt    = 1'b0;
          held_nxt   = '0;
          svc_nxt    = 1'b0;
        end
        default: begin
          // unused request codes leave state alone
        end
      endcase
    end
    res.srq = svc_nxt;
  end

  // head addresses follow the pointer as it will be after this edge
  assign ra0 = rd_ptr_nxt;
  assign ra1 = rd_ptr_nxt + PTR_W'(1);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_ptr_r] <= wdata;
    end
    head0_mem_r <= mem[ra0];
    head1_mem_r <= mem[ra1];
    fwd0_r      <= we && (wr_ptr_r == ra0);
    fwd1_r      <= we && (wr_ptr_r == ra1);
    fwd_data_r  <= wdata;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (fire) begin
      out_r <= res;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      tip_r    <= 1'b0;
      held_r   <= '0;
      svc_r    <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (fire) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      tip_r    <= tip_nxt;
      held_r   <= held_nxt;
      svc_r    <= svc_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

### sim/testbench.sv
// testbench for the desktop-bus keyboard event fifo: directed and random requests
// depends on adb_kbd_pkg and adb_keyboard_event_fifo_top
module testbench;
  import adb_kbd_pkg::*;

  // request codes the block treats as no-ops
  localparam logic [2:0] REQ_SPARE_6 = 3'd6;
  localparam logic [2:0] REQ_SPARE_7 = 3'd7;

  localparam int RANDOM_WORDS = 750;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  adb_keyboard_event_fifo_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // the run must never get near this; reaching it means the block hung
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  // expected behaviour of the keyboard: its own copy of the fifo and flags
  logic [7:0]       kbd_codes [FIFO_DEPTH];
  logic [PTR_W-1:0] kbd_rd = '0;
  logic [PTR_W-1:0] kbd_wr = '0;
  logic             kbd_talking = 1'b0;
  logic [15:0]      kbd_held = '0;
  logic             kbd_srq = 1'b0;

  out_t pending_replies [$];
  int   mismatch_count = 0;
  int   random_words = 0;
  bit   steady_flow = 1'b0;  // no idling on either side while set

  function automatic void push_code(input logic [7:0] code);
    logic [PTR_W-1:0] nxt;
    nxt = kbd_wr + PTR_W'(1);
    if (nxt != kbd_rd) begin
      kbd_codes[kbd_wr] = code;
      kbd_wr = nxt;
    end
  endfunction

  function automatic logic [7:0] pop_code();
    logic [7:0] code;
    code = kbd_codes[kbd_rd];
    kbd_rd = kbd_rd + PTR_W'(1);
    return code;
  endfunction

  function automatic out_t predict_reply(input in_t w);
    out_t       r;
    logic [7:0] hi;
    logic [7:0] lo;
    r = '0;
    case (w.req_type)
      REQ_KEY_DOWN: begin
        push_code({1'b0, w.key_code});
        kbd_srq = (kbd_rd != kbd_wr);
      end
      REQ_KEY_UP: begin
        push_code(RELEASE_BIT | {1'b0, w.key_code});
        kbd_srq = (kbd_rd != kbd_wr);
      end
      REQ_TALK_R0: begin
        // empty fifo with no talk open gives no bytes and changes nothing
        if (kbd_talking || kbd_rd != kbd_wr) begin
          if (!kbd_talking) begin
            hi = pop_code();
            lo = (kbd_rd == kbd_wr) ? NO_CODE : pop_code();
            kbd_held = {hi, lo};
          end
          kbd_talking = 1'b1;
          r.talk_len  = TALK_BYTES;
          r.talk_data = kbd_held;
        end
      end
      REQ_TALK_R2: begin
        r.talk_len  = TALK_BYTES;
        r.talk_data = REG2_WORD;
      end
      REQ_TALK_DONE: begin
        kbd_talking = 1'b0;
        kbd_srq = (kbd_rd != kbd_wr);
      end
      REQ_FLUSH: begin
        kbd_rd      = '0;
        kbd_wr      = '0;
        kbd_talking = 1'b0;
        kbd_held    = '0;
        kbd_srq     = 1'b0;
      end
      default: ;
    endcase
    r.srq = kbd_srq;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // one request word: random idle gaps, then hold valid until taken
  task automatic send_word(input logic [2:0] req, input logic [6:0] key);
    in_t w;
    w.req_type = req;
    w.key_code = key;
    @(negedge clk);
    while (!steady_flow && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_replies.push_back(predict_reply(w));
  endtask

  // stop sending and let every outstanding reply come back
  task automatic wait_replies_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // result side stalls at random, except in the steady stretch
  always @(negedge clk) begin
    out_ready <= steady_flow ? 1'b1 : ($urandom_range(99) >= 21);
  end

  out_t want;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("reply with nothing pending", out_data.talk_data, '0);
      end else begin
        want = pending_replies.pop_front();
        if (out_data.talk_len !== want.talk_len)
          report_mismatch("talk_len", 16'(out_data.talk_len), 16'(want.talk_len));
        if (out_data.talk_data !== want.talk_data)
          report_mismatch("talk_data", out_data.talk_data, want.talk_data);
        if (out_data.srq !== want.srq)
          report_mismatch("srq", 16'(out_data.srq), 16'(want.srq));
      end
    end
  end

  // talks on the empty fifo right after reset, register 2 and the spare codes
  task automatic test_idle_requests();
    send_word(REQ_TALK_R0, 7'h00);
    send_word(REQ_TALK_DONE, 7'h7f);
    send_word(REQ_TALK_R2, 7'h2a);
    send_word(REQ_SPARE_6, 7'h55);
    send_word(REQ_SPARE_7, 7'h7f);
  endtask

  // extreme key codes, a two-code talk repeated until talk-done
  task automatic test_key_extremes();
    send_word(REQ_KEY_DOWN, 7'h00);
    send_word(REQ_KEY_UP, 7'h7f);
    send_word(REQ_TALK_R0, 7'h00);
    send_word(REQ_TALK_R0, 7'h7f);
    send_word(REQ_TALK_DONE, 7'h00);
  endtask

  // fill past capacity so the last push is lost, flush, then a lone code
  // which comes back with 0xff in the low byte
  task automatic test_full_and_flush();
    for (int i = 0; i < FIFO_DEPTH; i++)
      send_word((i % 2) ? REQ_KEY_UP : REQ_KEY_DOWN, 7'(i * 9 + 3));
    send_word(REQ_FLUSH, 7'h11);
    send_word(REQ_KEY_DOWN, 7'h55);
    send_word(REQ_TALK_R0, 7'h00);
    send_word(REQ_TALK_DONE, 7'h00);
  endtask

  task automatic random_word(input logic [2:0] req);
    random_words++;
    send_word(req, 7'($urandom_range(127)));
  endtask

  // mostly whole host sessions (key events, talks, talk-done) with noise mixed in
  task automatic test_random_sessions();
    int  burst;
    bit  paused;
    paused = 1'b0;
    while (random_words < RANDOM_WORDS) begin
      steady_flow = (random_words >= 300 && random_words < 450);
      if (!paused && random_words >= 520) begin
        wait_replies_drained();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 80) begin
        // an occasional long burst can run the fifo into its full state
        burst = ($urandom_range(9) == 0) ? $urandom_range(20, 12) : $urandom_range(6, 0);
        repeat (burst) random_word($urandom_range(1) ? REQ_KEY_UP : REQ_KEY_DOWN);
        repeat ($urandom_range(3, 1)) begin
          random_word(REQ_TALK_R0);
          if ($urandom_range(9) == 0) random_word(REQ_TALK_R2);
        end
        if ($urandom_range(19) != 0) random_word(REQ_TALK_DONE);
      end else begin
        repeat ($urandom_range(4, 1)) random_word(3'($urandom_range(7)));
      end
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_idle_requests();
    test_key_extremes();
    test_full_and_flush();
    test_random_sessions();
    wait_replies_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
src/adb_kbd_pkg.sv
src/adb_keyboard_event_fifo_top.sv
sim/testbench.sv
